@@ rtl/core/dclt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package dclt_pkg;

   localparam int unsigned MS_WIDTH    = 16;
   localparam int unsigned TALLY_WIDTH = 4;
   localparam int unsigned CSR_IDX_W   = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CLAP_WINDOW = 2'd0,
      CSR_CLAPS_NEED  = 2'd1,
      CSR_DEBOUNCE    = 2'd2
   } csr_idx_type;

   typedef enum logic [1:0] {
      PHASE_IDLE     = 2'd0,
      PHASE_DEBOUNCE = 2'd1,
      PHASE_WAIT     = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      CAUSE_NONE   = 2'd0,
      CAUSE_BUTTON = 2'd1,
      CAUSE_CLAP   = 2'd2
   } cause_type;

   localparam logic [MS_WIDTH-1:0]    CLAP_WINDOW_RESET = 16'd1000;
   localparam logic [TALLY_WIDTH-1:0] CLAPS_NEED_RESET  = 4'd2;
   localparam logic [MS_WIDTH-1:0]    DEBOUNCE_RESET    = 16'd100;

   typedef struct packed {
      logic mic_level;
      logic button_level;
      logic ms_tick;
   } sample_type;

   typedef struct packed {
      logic      light_on;
      logic      clap_seen;
      logic      light_toggled;
      cause_type toggle_cause;
   } result_type;

   typedef struct packed {
      logic [MS_WIDTH-1:0]    clap_window_ms;
      logic [TALLY_WIDTH-1:0] claps_needed;
      logic [MS_WIDTH-1:0]    debounce_ms;
   } cfg_type;

endpackage

`default_nettype wire

@@ rtl/core/dclt_ifs.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface dclt_req_if;
   logic valid;
   logic ready;
   logic mic_level;
   logic button_level;
   logic ms_tick;

   modport source (output valid, mic_level, button_level, ms_tick, input ready);
   modport sink (input valid, mic_level, button_level, ms_tick, output ready);
endinterface

interface dclt_rsp_if;
   logic       valid;
   logic       ready;
   logic       light_on;
   logic       clap_seen;
   logic       light_toggled;
   logic [1:0] toggle_cause;

   modport source (output valid, light_on, clap_seen, light_toggled, toggle_cause,
                   input ready);
   modport sink (input valid, light_on, clap_seen, light_toggled, toggle_cause,
                 output ready);
endinterface

interface dclt_csr_if;
   logic                           valid;
   logic                           ready;
   logic [dclt_pkg::CSR_IDX_W-1:0] index;
   logic [dclt_pkg::MS_WIDTH-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/dclt_csr.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dclt_csr (
   input  wire logic               clock,
   input  wire logic               reset,
   dclt_csr_if.sink                csr,
   output dclt_pkg::cfg_type       cfg
);

   dclt_pkg::cfg_type cfg_ff;
   dclt_pkg::cfg_type cfg_in;

   assign csr.ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         unique case (csr.index)
            dclt_pkg::CSR_CLAP_WINDOW: cfg_in.clap_window_ms = csr.data;
            dclt_pkg::CSR_CLAPS_NEED:
               cfg_in.claps_needed = csr.data[dclt_pkg::TALLY_WIDTH-1:0];
            dclt_pkg::CSR_DEBOUNCE:    cfg_in.debounce_ms = csr.data;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.clap_window_ms <= dclt_pkg::CLAP_WINDOW_RESET;
         cfg_ff.claps_needed   <= dclt_pkg::CLAPS_NEED_RESET;
         cfg_ff.debounce_ms    <= dclt_pkg::DEBOUNCE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/dclt_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dclt_core (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 advance,
   input  wire dclt_pkg::sample_type sample,
   input  wire dclt_pkg::cfg_type    cfg,
   output dclt_pkg::result_type      result
);

   localparam int unsigned MW = dclt_pkg::MS_WIDTH;
   localparam int unsigned TW = dclt_pkg::TALLY_WIDTH;

   dclt_pkg::phase_type phase_ff, phase_in;
   logic [MW-1:0]       debounce_left_ff, debounce_left_in;
   logic [MW-1:0]       elapsed_ms_ff, elapsed_ms_in;
   logic [MW-1:0]       last_clap_ms_ff, last_clap_ms_in;
   logic [TW-1:0]       clap_tally_ff, clap_tally_in;
   logic                light_ff, light_in;
   logic                prev_mic_ff, prev_mic_in;

   logic          pressed;
   logic [MW-1:0] debounce_dec;
   logic          press_confirm;
   logic          mic_sampled;
   logic          clap;
   logic [MW-1:0] gap;
   logic [TW-1:0] tally_next;
   logic          clap_toggle;

   assign pressed      = ~sample.button_level;
   assign debounce_dec = (sample.ms_tick && (debounce_left_ff != '0))
                         ? debounce_left_ff - MW'(1) : debounce_left_ff;

   assign press_confirm = pressed && (
      ((phase_ff == dclt_pkg::PHASE_DEBOUNCE) && (debounce_dec == '0)) ||
      ((phase_ff != dclt_pkg::PHASE_DEBOUNCE) && (phase_ff != dclt_pkg::PHASE_WAIT) &&
       (cfg.debounce_ms == '0)));

   // Button phase and debounce countdown.
   always_comb begin
      phase_in         = phase_ff;
      debounce_left_in = debounce_left_ff;
      unique case (phase_ff)
         dclt_pkg::PHASE_DEBOUNCE: begin
            debounce_left_in = debounce_dec;
            if (debounce_dec == '0) begin
               phase_in = pressed ? dclt_pkg::PHASE_WAIT : dclt_pkg::PHASE_IDLE;
            end
         end
         dclt_pkg::PHASE_WAIT: begin
            if (!pressed) begin
               phase_in = dclt_pkg::PHASE_IDLE;
            end
         end
         default: begin
            phase_in = dclt_pkg::PHASE_IDLE;
            if (pressed) begin
               if (cfg.debounce_ms == '0) begin
                  phase_in = dclt_pkg::PHASE_WAIT;
               end else begin
                  debounce_left_in = cfg.debounce_ms;
                  phase_in         = dclt_pkg::PHASE_DEBOUNCE;
               end
            end
         end
      endcase
   end

   // Clap detection, light and result.
   always_comb begin
      mic_sampled = (phase_in == dclt_pkg::PHASE_IDLE);
      clap        = mic_sampled && sample.mic_level && !prev_mic_ff;
      gap         = elapsed_ms_ff - last_clap_ms_ff;
      tally_next  = (gap < cfg.clap_window_ms) ? clap_tally_ff + TW'(1) : TW'(1);
      clap_toggle = clap && (tally_next >= cfg.claps_needed);

      clap_tally_in   = clap_tally_ff;
      last_clap_ms_in = last_clap_ms_ff;
      if (clap) begin
         clap_tally_in   = clap_toggle ? '0 : tally_next;
         last_clap_ms_in = elapsed_ms_ff;
      end
      prev_mic_in   = mic_sampled ? sample.mic_level : prev_mic_ff;
      light_in      = light_ff ^ (press_confirm | clap_toggle);
      elapsed_ms_in = elapsed_ms_ff + MW'(sample.ms_tick);

      result.light_on      = light_in;
      result.clap_seen     = clap;
      result.light_toggled = press_confirm | clap_toggle;
      if (press_confirm) begin
         result.toggle_cause = dclt_pkg::CAUSE_BUTTON;
      end else if (clap_toggle) begin
         result.toggle_cause = dclt_pkg::CAUSE_CLAP;
      end else begin
         result.toggle_cause = dclt_pkg::CAUSE_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= dclt_pkg::PHASE_IDLE;
         debounce_left_ff <= '0;
         elapsed_ms_ff    <= '0;
         last_clap_ms_ff  <= '0;
         clap_tally_ff    <= '0;
         light_ff         <= 1'b0;
         prev_mic_ff      <= 1'b0;
      end else if (advance) begin
         phase_ff         <= phase_in;
         debounce_left_ff <= debounce_left_in;
         elapsed_ms_ff    <= elapsed_ms_in;
         last_clap_ms_ff  <= last_clap_ms_in;
         clap_tally_ff    <= clap_tally_in;
         light_ff         <= light_in;
         prev_mic_ff      <= prev_mic_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/double_clap_light_toggle.sv @@
// A result beat is computed from the input register into the result register; its
// valid can be held back while the previous result beat stalls.
// Throughput: one request beat per cycle while the response side does not stall,
// set by the state update between the input register and the result register.
// Reset: synchronous and active high; it clears the pipeline valids and the core
// state, turns the light off and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module double_clap_light_toggle (
   input  wire logic  clock,
   input  wire logic  reset,
   dclt_req_if.sink   req,
   dclt_rsp_if.source rsp,
   dclt_csr_if.sink   csr
);

   dclt_pkg::cfg_type    cfg;
   dclt_pkg::sample_type sample_ff, sample_in;
   dclt_pkg::result_type result_ff, result_in;
   logic                 in_valid_ff, in_valid_in;
   logic                 out_valid_ff, out_valid_in;
   logic                 advance;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;

   assign sample_in.mic_level    = req.mic_level;
   assign sample_in.button_level = req.button_level;
   assign sample_in.ms_tick      = req.ms_tick;

   assign in_valid_in  = (req.valid && req.ready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp.ready);

   dclt_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr),
      .cfg   (cfg)
   );

   dclt_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .sample  (sample_ff),
      .cfg     (cfg),
      .result  (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         sample_ff <= sample_in;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.light_on      = result_ff.light_on;
   assign rsp.clap_seen     = result_ff.clap_seen;
   assign rsp.light_toggled = result_ff.light_toggled;
   assign rsp.toggle_cause  = result_ff.toggle_cause;

endmodule

`default_nettype wire

@@ rtl/core/dclt_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dclt_assertions (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_light_on,
   input wire logic       rsp_clap_seen,
   input wire logic       rsp_light_toggled,
   input wire logic [1:0] rsp_toggle_cause
);

   logic last_light_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_light_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         last_light_ff <= rsp_light_on;
      end
   end

   // The light level of each beat follows from the previous beat and the toggle flag.
   a_light_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |-> (rsp_light_on == (last_light_ff ^ rsp_light_toggled)))
      else $error("light level does not match toggle history");

   a_toggle_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_light_toggled == (rsp_toggle_cause != dclt_pkg::CAUSE_NONE)))
      else $error("toggle flag and cause disagree");

   // A button toggle pauses microphone sampling, so no clap can be counted with it.
   a_button_no_clap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_toggle_cause == dclt_pkg::CAUSE_BUTTON)) |-> !rsp_clap_seen)
      else $error("clap counted on a button toggle");

   a_no_valid_after_reset: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_valid)
      else $error("result beat valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_light_on) &&
                                      $stable(rsp_toggle_cause)))
      else $error("stalled result beat changed");

endmodule

bind double_clap_light_toggle dclt_assertions u_dclt_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_light_on      (rsp.light_on),
   .rsp_clap_seen     (rsp.clap_seen),
   .rsp_light_toggled (rsp.light_toggled),
   .rsp_toggle_cause  (rsp.toggle_cause)
);

`default_nettype wire

@@ dv/dclt_checker.sv @@
`timescale 1ns / 1ps

module dclt_checker (
   input  wire logic   clock,
   input  wire logic   reset,
   dclt_req_if         req,
   dclt_rsp_if         rsp,
   dclt_csr_if         csr,
   output int unsigned mismatches,
   output int unsigned results_due
);

   logic [dclt_pkg::MS_WIDTH-1:0]    window_ms;
   logic [dclt_pkg::TALLY_WIDTH-1:0] claps_req;
   logic [dclt_pkg::MS_WIDTH-1:0]    debounce_len;

   logic [dclt_pkg::MS_WIDTH-1:0]    ms_count;
   logic [dclt_pkg::MS_WIDTH-1:0]    last_clap_stamp;
   logic [dclt_pkg::TALLY_WIDTH-1:0] tally;
   logic                             light;
   logic                             mic_prev;
   dclt_pkg::phase_type              phase;
   logic [dclt_pkg::MS_WIDTH-1:0]    countdown;

   dclt_pkg::result_type             due_results[$];
   int unsigned                      error_tally = 0;

   function automatic dclt_pkg::result_type predict_light(input dclt_pkg::sample_type s);
      dclt_pkg::result_type          r;
      logic                          pressed;
      logic [dclt_pkg::MS_WIDTH-1:0] gap;
      r = '0;
      pressed = !s.button_level;
      case (phase)
         dclt_pkg::PHASE_DEBOUNCE: begin
            if (s.ms_tick && countdown != '0) begin
               countdown = countdown - 1'b1;
            end
            if (countdown == '0) begin
               if (pressed) begin
                  light = ~light;
                  r.light_toggled = 1'b1;
                  r.toggle_cause = dclt_pkg::CAUSE_BUTTON;
                  phase = dclt_pkg::PHASE_WAIT;
               end else begin
                  phase = dclt_pkg::PHASE_IDLE;
               end
            end
         end
         dclt_pkg::PHASE_WAIT: begin
            if (!pressed) begin
               phase = dclt_pkg::PHASE_IDLE;
            end
         end
         default: begin
            phase = dclt_pkg::PHASE_IDLE;
            if (pressed) begin
               if (debounce_len == '0) begin
                  light = ~light;
                  r.light_toggled = 1'b1;
                  r.toggle_cause = dclt_pkg::CAUSE_BUTTON;
                  phase = dclt_pkg::PHASE_WAIT;
               end else begin
                  countdown = debounce_len;
                  phase = dclt_pkg::PHASE_DEBOUNCE;
               end
            end
         end
      endcase

      // The microphone is only watched while the button logic rests.
      if (phase == dclt_pkg::PHASE_IDLE) begin
         if (s.mic_level && !mic_prev) begin
            gap = ms_count - last_clap_stamp;
            r.clap_seen = 1'b1;
            if (gap < window_ms) begin
               tally = tally + 1'b1;
            end else begin
               tally = 4'd1;
            end
            last_clap_stamp = ms_count;
            if (tally >= claps_req) begin
               light = ~light;
               r.light_toggled = 1'b1;
               r.toggle_cause = dclt_pkg::CAUSE_CLAP;
               tally = '0;
            end
         end
         mic_prev = s.mic_level;
      end

      if (s.ms_tick) begin
         ms_count = ms_count + 1'b1;
      end
      r.light_on = light;
      return r;
   endfunction

   always @(posedge clock) begin
      dclt_pkg::sample_type s;
      dclt_pkg::result_type want;
      dclt_pkg::result_type got;
      if (reset) begin
         window_ms       = dclt_pkg::CLAP_WINDOW_RESET;
         claps_req       = dclt_pkg::CLAPS_NEED_RESET;
         debounce_len    = dclt_pkg::DEBOUNCE_RESET;
         ms_count        = '0;
         last_clap_stamp = '0;
         tally           = '0;
         light           = 1'b0;
         mic_prev        = 1'b0;
         phase           = dclt_pkg::PHASE_IDLE;
         countdown       = '0;
         due_results.delete();
      end else begin
         if (csr.valid && csr.ready) begin
            case (csr.index)
               dclt_pkg::CSR_CLAP_WINDOW: window_ms = csr.data;
               dclt_pkg::CSR_CLAPS_NEED:
                  claps_req = csr.data[dclt_pkg::TALLY_WIDTH-1:0];
               dclt_pkg::CSR_DEBOUNCE:    debounce_len = csr.data;
               default: ;
            endcase
         end
         if (req.valid && req.ready) begin
            s.mic_level    = req.mic_level;
            s.button_level = req.button_level;
            s.ms_tick      = req.ms_tick;
            due_results.push_back(predict_light(s));
         end
         if (rsp.valid && rsp.ready) begin
            got.light_on      = rsp.light_on;
            got.clap_seen     = rsp.clap_seen;
            got.light_toggled = rsp.light_toggled;
            got.toggle_cause  = dclt_pkg::cause_type'(rsp.toggle_cause);
            if (due_results.size() == 0) begin
               error_tally++;
               $display("%0t: result beat with none expected, actual light %0b clap %0b",
                        $time, got.light_on, got.clap_seen);
            end else begin
               want = due_results.pop_front();
               if (got !== want) begin
                  error_tally++;
                  $display({"%0t: result mismatch, expected light %0b clap %0b ",
                            "toggled %0b cause %0d, actual light %0b clap %0b ",
                            "toggled %0b cause %0d"},
                           $time, want.light_on, want.clap_seen, want.light_toggled,
                           want.toggle_cause, got.light_on, got.clap_seen,
                           got.light_toggled, got.toggle_cause);
               end
            end
         end
      end
      mismatches  <= error_tally;
      results_due <= due_results.size();
   end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam logic [dclt_pkg::CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        quiet = 1'b0;
   int unsigned mismatches;
   int unsigned results_due;
   int unsigned cycle_count = 0;
   int unsigned rsp_stall = 0;

   dclt_req_if req();
   dclt_rsp_if rsp();
   dclt_csr_if csr();

   double_clap_light_toggle i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp),
      .csr   (csr)
   );

   dclt_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .rsp         (rsp),
      .csr         (csr),
      .mismatches  (mismatches),
      .results_due (results_due)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp.ready <= 1'b1;
         rsp_stall <= 0;
      end else if (rsp_stall != 0) begin
         rsp.ready <= 1'b0;
         rsp_stall <= rsp_stall - 1;
      end else if ($urandom_range(0, 9) == 0) begin
         rsp.ready <= 1'b0;
         rsp_stall <= $urandom_range(0, 7);
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   task automatic send_sample(input logic mic, input logic btn, input logic tick);
      int unsigned gap;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 8);
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid        <= 1'b1;
      req.mic_level    <= mic;
      req.button_level <= btn;
      req.ms_tick      <= tick;
      do @(posedge clock); while (!req.ready);
   endtask

   task automatic settle();
      req.valid <= 1'b0;
      do @(posedge clock); while (results_due != 0);
   endtask

   task automatic write_reg(input logic [dclt_pkg::CSR_IDX_W-1:0] idx,
                            input logic [dclt_pkg::MS_WIDTH-1:0] value);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data  <= value;
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(input logic [dclt_pkg::MS_WIDTH-1:0] window,
                             input logic [dclt_pkg::MS_WIDTH-1:0] claps,
                             input logic [dclt_pkg::MS_WIDTH-1:0] debounce);
      settle();
      write_reg(dclt_pkg::CSR_CLAP_WINDOW, window);
      write_reg(dclt_pkg::CSR_CLAPS_NEED, claps);
      write_reg(dclt_pkg::CSR_DEBOUNCE, debounce);
   endtask

   // Clap bursts and button presses of random length, up to long enough to outlast
   // the debounce, with single-sample glitches mixed in.
   task automatic run_random(input int unsigned count, input int unsigned tick_pct,
                             input int unsigned debounce);
      int unsigned mic_left;
      int unsigned btn_left;
      logic        mic;
      logic        btn;
      logic        tick;
      mic_left = 0;
      btn_left = 0;
      mic = 1'b0;
      btn = 1'b1;
      for (int unsigned n = 0; n < count; n++) begin
         if (mic_left == 0) begin
            mic = ~mic;
            mic_left = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 30)
                                                    : $urandom_range(1, 3);
         end
         if (btn_left == 0) begin
            btn = ($urandom_range(0, 2) == 0) ? 1'b0 : 1'b1;
            btn_left = btn ? $urandom_range(1, 15)
                           : $urandom_range(1, (debounce + 2) * 100 / tick_pct + 4);
         end
         mic_left--;
         btn_left--;
         tick = ($urandom_range(1, 100) <= tick_pct);
         if ($urandom_range(0, 11) == 0) begin
            send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), tick);
         end else begin
            send_sample(mic, btn, tick);
         end
      end
   endtask

   initial begin
      int unsigned deb;
      req.valid        = 1'b0;
      req.mic_level    = 1'b0;
      req.button_level = 1'b1;
      req.ms_tick      = 1'b0;
      csr.valid        = 1'b0;
      csr.index        = dclt_pkg::CSR_CLAP_WINDOW;
      csr.data         = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Two close claps under the reset settings.
      send_sample(1'b0, 1'b1, 1'b0);
      send_sample(1'b1, 1'b1, 1'b0);
      send_sample(1'b0, 1'b1, 1'b1);
      send_sample(1'b1, 1'b1, 1'b0);
      send_sample(1'b1, 1'b1, 1'b1);

      // Zero window, one clap needed, zero debounce; the spare index is ignored.
      set_config(16'd0, 16'd1, 16'd0);
      write_reg(CSR_SPARE, 16'hFFFF);
      send_sample(1'b0, 1'b1, 1'b0);
      send_sample(1'b1, 1'b1, 1'b0);
      send_sample(1'b0, 1'b0, 1'b0);
      send_sample(1'b1, 1'b0, 1'b1);
      send_sample(1'b1, 1'b1, 1'b0);

      // Claps needed masks to zero; a failed debounce, then a confirmed press.
      set_config(16'd3, 16'hFFF0, 16'd2);
      send_sample(1'b0, 1'b1, 1'b0);
      send_sample(1'b1, 1'b1, 1'b1);
      send_sample(1'b0, 1'b0, 1'b0);
      send_sample(1'b1, 1'b0, 1'b1);
      send_sample(1'b0, 1'b1, 1'b1);
      send_sample(1'b0, 1'b0, 1'b1);
      send_sample(1'b0, 1'b0, 1'b1);
      send_sample(1'b0, 1'b0, 1'b1);
      send_sample(1'b0, 1'b0, 1'b0);
      send_sample(1'b0, 1'b1, 1'b0);

      set_config(16'd4, 16'd2, 16'd2);
      run_random(150, 50, 2);
      set_config(16'd1, 16'd3, 16'd0);
      run_random(150, 30, 0);
      set_config(16'd0, 16'd1, 16'd5);
      run_random(150, 60, 5);
      set_config(16'hFFFF, 16'd15, 16'd1);
      run_random(150, 50, 1);
      set_config(16'd8, 16'd0, 16'd3);
      run_random(150, 100, 3);
      deb = $urandom_range(0, 6);
      set_config(16'($urandom_range(1, 20)), 16'($urandom_range(0, 16'hFFFF)), 16'(deb));
      run_random(150, 40, deb);
      set_config(16'd10, 16'd4, 16'd2);
      run_random(75, 50, 2);
      settle();
      run_random(75, 50, 2);

      // Long debounce held to its end while the microphone toggles unheard.
      quiet <= 1'b1;
      set_config(16'hFFFF, 16'd2, 16'd12);
      repeat (4) send_sample(1'b0, 1'b1, 1'b1);
      send_sample(1'b1, 1'b1, 1'b0);
      send_sample(1'b0, 1'b1, 1'b0);
      send_sample(1'b0, 1'b0, 1'b0);
      repeat (14) send_sample(1'($urandom_range(0, 1)), 1'b0, 1'b1);
      send_sample(1'b0, 1'b1, 1'b0);
      send_sample(1'b1, 1'b1, 1'b0);

      set_config(16'd3, 16'd2, 16'd1);
      run_random(150, 50, 1);

      settle();
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/dclt_pkg.sv
rtl/core/dclt_ifs.sv
rtl/core/dclt_csr.sv
rtl/core/dclt_core.sv
rtl/core/double_clap_light_toggle.sv
rtl/core/dclt_checker.sv
dv/dclt_checker.sv
dv/tb_top.sv
